// ----- sv/sis_pkg.sv -----
// Package for the sorted insertion stack: depth, command, status and cell codes.
// Shared by sis_cell and sorted_insertion_stack; depends on nothing.
package sis_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;

  // command codes
  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;
  localparam logic [1:0] CMD_SORT   = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_INSERT,
    CELL_EXCHANGE
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [DataW-1:0]  value;
  } cell_ctrl_t;

endpackage

// ----- sv/sis_cell.sv -----
// One stack cell: holds a single entry and trades it with its neighbours.
// Depends on sis_pkg.
module sis_cell (
  input  logic                      clk_i,
  input  sis_pkg::cell_ctrl_t       ctrl_i,
  input  logic                      pair_dn_i,
  input  logic                      occ_i,
  input  logic                      up_occ_i,
  input  logic                      dn_occ_i,
  input  logic [sis_pkg::DataW-1:0] up_val_i,
  input  logic [sis_pkg::DataW-1:0] dn_val_i,
  input  logic                      run_i,
  output logic                      run_o,
  output logic [sis_pkg::DataW-1:0] entry_o
);
  import sis_pkg::*;

  logic [DataW-1:0] entry_q, entry_d;
  logic             lt_val, lt_dn, lt_up;

  assign lt_val = $signed(entry_q) < $signed(ctrl_i.value);
  assign lt_dn  = $signed(entry_q) < $signed(dn_val_i);
  assign lt_up  = $signed(up_val_i) < $signed(entry_q);

  // the run stays alive while every entry from the top down is >= value
  assign run_o = run_i & occ_i & ~lt_val;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_PUSH: entry_d = up_val_i;
      CELL_POP:  entry_d = dn_val_i;
      CELL_INSERT: begin
        if (!run_i) begin
          entry_d = up_val_i;
        end else if (!occ_i || lt_val) begin
          entry_d = ctrl_i.value;
        end
      end
      CELL_EXCHANGE: begin
        if (pair_dn_i) begin
          // upper cell of the pair keeps the larger value
          if (occ_i && dn_occ_i && lt_dn) entry_d = dn_val_i;
        end else begin
          // lower cell of the pair keeps the smaller value
          if (occ_i && up_occ_i && lt_up) entry_d = up_val_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- sv/sorted_insertion_stack.sv -----
// Top level of the sorted insertion stack: a chain of sis_cell entries and its
// command sequencer. Depends on sis_pkg and sis_cell.
//
// Usage: drive command_i and value_i and raise start; the command is taken
// at a rising edge where start is high and busy is low (one transaction).
// Every command yields exactly one result, shown for one cycle with valid_o
// high: popped value, top value (-1 when empty), empty flag, count, status.
// Cell 0 is the top of the stack; each command moves the whole chain at once.
// Push, pop and sorted insert: result in the cycle after acceptance, and a
// new command may be taken in every cycle, so throughput is one per cycle.
// The insert point is found by a run signal passed from the top cell down.
// Sort all: with n entries held (n >= 2) the chain runs n odd-even exchange
// phases, one per cycle, with busy high; the result follows the last phase.
// With fewer than two entries it leaves the stack unchanged, with status ok.
// A push or insert on a full stack is dropped with status full; a pop on an
// empty stack returns 0 with status empty.
// Reset clears the fill level and the sequencer; entry contents are left as
// they are and are never read before being written.
// The receiver cannot stall: each result must be taken in its strobe cycle.
module sorted_insertion_stack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command_i,
  input  logic signed [sis_pkg::DataW-1:0] value_i,
  output logic              valid_o,
  output logic signed [sis_pkg::DataW-1:0] popped_value_o,
  output logic signed [sis_pkg::DataW-1:0] top_value_o,
  output logic              is_empty_o,
  output logic [4:0]        entry_count_o,
  output logic [1:0]        status_o
);
  import sis_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SORT = 1'b1;

  logic             state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             phase_q, phase_d;
  logic             valid_q, valid_d;
  logic [DataW-1:0] popped_q, popped_d;
  logic [1:0]       status_q, status_d;

  logic             accept;
  logic             full, empty;
  cell_ctrl_t       ctrl;

  logic [DataW-1:0] entry  [Depth];
  logic [DataW-1:0] up_val [Depth];
  logic [DataW-1:0] dn_val [Depth];
  logic             occ    [Depth];
  logic             up_occ [Depth];
  logic             dn_occ [Depth];
  logic             pair_dn[Depth];
  logic             run    [Depth+1];

  assign busy   = (state_q == ST_SORT);
  assign accept = start & ~busy;
  assign full   = (fill_q == CntW'(Depth));
  assign empty  = (fill_q == '0);

  // neighbour wiring; the chain ends see an empty neighbour
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      occ[i]     = (fill_q > CntW'(i));
      pair_dn[i] = ((i % 2) == 0) ? ~phase_q : phase_q;
      if (i == 0) begin
        up_val[i] = ctrl.value;
        up_occ[i] = 1'b0;
      end else begin
        up_val[i] = entry[i-1];
        up_occ[i] = occ[i-1];
      end
      if (i == Depth - 1) begin
        dn_val[i] = entry[i];
        dn_occ[i] = 1'b0;
      end else begin
        dn_val[i] = entry[i+1];
        dn_occ[i] = (fill_q > CntW'(i + 1));
      end
    end
  end

  assign run[0] = 1'b1;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    sis_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .pair_dn_i (pair_dn[g]),
      .occ_i     (occ[g]),
      .up_occ_i  (up_occ[g]),
      .dn_occ_i  (dn_occ[g]),
      .up_val_i  (up_val[g]),
      .dn_val_i  (dn_val[g]),
      .run_i     (run[g]),
      .run_o     (run[g+1]),
      .entry_o   (entry[g])
    );
  end

  // sequencer: decode commands and step the sort phases
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    phase_d    = phase_q;
    valid_d    = 1'b0;
    popped_d   = popped_q;
    status_d   = status_q;
    ctrl.op    = CELL_HOLD;
    ctrl.value = value_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          popped_d = '0;
          status_d = STAT_OK;
          valid_d  = 1'b1;
          unique case (command_i)
            CMD_PUSH: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.op = CELL_PUSH;
                fill_d  = fill_q + 1'b1;
              end
            end
            CMD_POP: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else begin
                ctrl.op  = CELL_POP;
                fill_d   = fill_q - 1'b1;
                popped_d = entry[0];
              end
            end
            CMD_INSERT: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.op = CELL_INSERT;
                fill_d  = fill_q + 1'b1;
              end
            end
            CMD_SORT: begin
              // hold the result back until the last exchange phase
              if (fill_q > CntW'(1)) begin
                valid_d = 1'b0;
                state_d = ST_SORT;
                cnt_d   = fill_q;
                phase_d = 1'b0;
              end
            end
            default: status_d = STAT_OK;
          endcase
        end
      end
      ST_SORT: begin
        ctrl.op = CELL_EXCHANGE;
        phase_d = ~phase_q;
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = ST_IDLE;
          valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
      phase_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
    status_q <= status_d;
  end

  assign valid_o        = valid_q;
  assign popped_value_o = popped_q;
  assign top_value_o    = empty ? '1 : entry[0];
  assign is_empty_o     = empty;
  assign entry_count_o  = 5'(fill_q);
  assign status_o       = status_q;

  // a full report only ever comes from a stack that is at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == STAT_FULL) |-> full)
    else $error("full status with spare capacity");

  // no result is shown while the sort phases are still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !valid_o)
    else $error("result strobe during sort");

  // the phase counter never runs dry while sorting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT) |-> (cnt_q != '0))
    else $error("sort phase counter at zero");

  // fill level stays within the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(Depth))
    else $error("fill level beyond depth");

  // an empty pop returns zero and leaves the stack empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == STAT_EMPTY) |-> (popped_value_o == '0) && is_empty_o)
    else $error("empty pop returned data");

endmodule
